[rtl/slot_buffer_pool_manager_top_defines.svh]
// Assertion macros for the slot buffer pool manager top level.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef SLOT_BUFFER_POOL_MANAGER_TOP_DEFINES_SVH
`define SLOT_BUFFER_POOL_MANAGER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBPM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbpm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbpm: next-cycle check failed");

`endif

[rtl/sbpm_pkg.sv]
// Shared types, codes and constants of the slot buffer pool manager.
// Used by sbpm_ctrl, sbpm_datapath and slot_buffer_pool_manager_top.
package sbpm_pkg;

  localparam int IDX_W      = 6;
  localparam int SLOT_W     = 3;
  localparam int BYTES_W    = 25;
  localparam int OFFS_W     = 30;
  localparam int PER_W      = 7;
  localparam int POS_W      = 6;
  localparam int SLOTS_W    = 4;
  localparam int BASE_W     = 10;
  localparam int MUL_W      = IDX_W + BYTES_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [BYTES_W-1:0] BYTES_MAX = 25'd16777216;
  localparam logic [PER_W-1:0]   PER_MAX   = 7'd64;

  localparam int POOL_SIZE_DEF   = 64;
  localparam int MAX_SLOTS_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 8;

  typedef enum logic [1:0] {
    ACT_FIND    = 2'd0,
    ACT_ACQUIRE = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_WRITE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_BYTES     = 2'd0,
    REG_BUFFERS_PER_SLOT = 2'd1,
    REG_SLOTS_IN_USE     = 2'd2
  } reg_index_t;

  typedef struct packed {
    action_t             action;
    logic [SLOT_W-1:0]   slot;
    logic [IDX_W-1:0]    buffer_index;
    logic [BYTES_W-1:0]  length;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [IDX_W-1:0]    found_index;
    logic [OFFS_W-1:0]   byte_offset;
    logic [BYTES_W-1:0]  stored_length;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    decode;
    logic    scan;
    logic    access;
    logic    capture;
    status_t status;
    logic    clr_restart;
    logic    clr_write;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_find;
    logic n_zero;
    logic bad_len;
    logic in_slot;
    logic scan_hit;
    logic scan_full;
    logic clr_last;
  } dp_stat_t;

endpackage

[rtl/slot_buffer_pool_manager_top.sv]
// Top level of the slot buffer pool manager: controller plus datapath.
// Depends on sbpm_pkg, sbpm_ctrl, sbpm_datapath and the defines header.
//
// Usage: a request (action, slot, buffer_index, length) is taken on a rising
// edge where start is high and busy is low. Exactly one result follows unless a
// listed register write drops the request; it is shown on out_item for a single
// cycle while out_valid is high, and the receiver must take it then, since it
// cannot stall the block. A request rejected by decode (bad length, index
// outside the slot, empty slot) is answered after the decode state; acquire,
// release and write pass through decode and access; a find passes through
// decode and then scans the slot from its search pointer until an unused
// buffer is hit or all are in use. The find time is set by the scan, which
// reads one use count per cycle from the single read port of the count
// memory. busy drops in the cycle the result is shown, so a new request can
// be taken there; one request is in work at a time.
// The configuration port writes buffer_bytes, buffers_per_slot and
// slots_in_use by index with no wait. After reset, and after every write to
// one of those registers, a clearing pass over all POOL_SIZE entries rebuilds
// the use counts, recorded lengths and search pointers while busy stays high.
`include "slot_buffer_pool_manager_top_defines.svh"

module slot_buffer_pool_manager_top import sbpm_pkg::*; #(
  parameter int POOL_SIZE   = POOL_SIZE_DEF,
  parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Used by the checks below: a write to one of the listed registers, and a
  // result that reports a full slot.
  logic cfg_reg_write;
  logic full_result;

  // The controller sequences decode, scan, memory update and the clear pass.
  sbpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the registers, memories and the result register.
  sbpm_datapath #(
    .POOL_SIZE   (POOL_SIZE),
    .MAX_SLOTS   (MAX_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

  assign cfg_reg_write = cfg_we && (cfg_index == REG_BUFFER_BYTES ||
                                    cfg_index == REG_BUFFERS_PER_SLOT ||
                                    cfg_index == REG_SLOTS_IN_USE);
  assign full_result   = out_valid && (out_item.status == ST_FULL);

  // An accepted request keeps the block busy in the following cycle.
  `SBPM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result only comes out of work that was under way.
  `SBPM_ASSERT_SAME(a_result_after_work, out_valid, $past(busy))
  // A register write starts the clear pass and cancels any pending result.
  `SBPM_ASSERT_NEXT(a_cfg_clears, cfg_reg_write, busy && !out_valid)
  // A full slot reports buffer index zero.
  `SBPM_ASSERT_SAME(a_full_zero_index, full_result, out_item.found_index == '0)

endmodule

[rtl/sbpm_ctrl.sv]
// Controller state machine of the slot buffer pool manager.
// Depends on sbpm_pkg; drives the commands of sbpm_datapath.
module sbpm_ctrl import sbpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  dp_stat_t             stat,
  output ctrl_cmd_t            cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ACCESS
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   cfg_listed;

  assign cfg_listed = cfg_we && (cfg_index == REG_BUFFER_BYTES ||
                                 cfg_index == REG_BUFFERS_PER_SLOT ||
                                 cfg_index == REG_SLOTS_IN_USE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = ST_OK;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_IDLE;
        priority if (stat.is_find) begin
          if (stat.n_zero) begin
            cmd.capture = 1'b1;
            cmd.status  = ST_NOT_FOUND;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (stat.bad_len) begin
          cmd.capture = 1'b1;
          cmd.status  = ST_BAD_LEN;
        end else if (!stat.in_slot) begin
          cmd.capture = 1'b1;
          cmd.status  = ST_NOT_FOUND;
        end else begin
          state_nxt = S_ACCESS;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (stat.scan_hit) begin
          cmd.capture = 1'b1;
          cmd.status  = ST_OK;
          state_nxt   = S_IDLE;
        end else if (stat.scan_full) begin
          cmd.capture = 1'b1;
          cmd.status  = ST_FULL;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_ACCESS: begin
        cmd.access  = 1'b1;
        cmd.capture = 1'b1;
        cmd.status  = ST_OK;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // A register write rebuilds the pool and drops whatever was in flight.
    if (cfg_listed) begin
      cmd             = '0;
      cmd.status      = ST_OK;
      cmd.clr_restart = 1'b1;
      state_nxt       = S_CLEAR;
    end

    out_valid_nxt = cmd.capture;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/sbpm_datapath.sv]
// Datapath of the slot buffer pool manager: registers, count and length
// memories, slot decode, scan unit and result register. Depends on sbpm_pkg.
module sbpm_datapath import sbpm_pkg::*; #(
  parameter int POOL_SIZE   = POOL_SIZE_DEF,
  parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_item,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output out_item_t             out_item
);

  localparam int PW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int SPW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos,
                                                input logic [PER_W-1:0] n);
    logic [PER_W-1:0] p1;
    p1 = PER_W'(pos) + PER_W'(1);
    return (p1 < n) ? p1[POS_W-1:0] : '0;
  endfunction

  // Configuration registers, stored as written.
  logic [BYTES_W-1:0] bytes_r;
  logic [PER_W-1:0]   bps_r;
  logic [SLOTS_W-1:0] sir_r;

  // Effective values after clamping.
  logic [BYTES_W-1:0] eff_bytes;
  logic [PER_W-1:0]   per_eff;
  logic [SLOTS_W-1:0] sir_eff;

  in_item_t req_r;

  // Slot decode.
  logic              slot_ok;
  logic [BASE_W-1:0] base_dec;
  logic [BASE_W-1:0] idx_ext;
  logic [PER_W-1:0]  n_dec;
  logic              in_slot_dec;
  logic [POS_W-1:0]  ptr_cur;
  logic [POS_W-1:0]  pos0;
  logic [MUL_W-1:0]  prod;

  // Scan and access registers.
  logic [BASE_W-1:0] base_r;
  logic [PER_W-1:0]  n_r;
  logic [POS_W-1:0]  iss_pos_r;
  logic [PER_W-1:0]  iss_cnt_r;
  logic [POS_W-1:0]  chk_pos_r;
  logic              chk_vld_r;
  logic [OFFS_W-1:0] offset_r;
  logic              issue_ok;

  logic [POS_W-1:0]  ptr_r [MAX_SLOTS];
  logic [PW-1:0]     clr_addr_r;
  logic              clr_last;

  logic [COUNT_WIDTH-1:0] use_mem [POOL_SIZE];
  logic [BYTES_W-1:0]     len_mem [POOL_SIZE];
  logic [COUNT_WIDTH-1:0] rd_cnt_r;
  logic [BYTES_W-1:0]     rd_len_r;
  logic [PW-1:0]          rd_addr;
  logic [PW-1:0]          acc_addr;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [BYTES_W-1:0]     len_clamped;

  out_item_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= 25'd1;
      bps_r   <= 7'd1;
      sir_r   <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUFFER_BYTES:     bytes_r <= cfg_wdata;
        REG_BUFFERS_PER_SLOT: bps_r   <= cfg_wdata[PER_W-1:0];
        REG_SLOTS_IN_USE:     sir_r   <= cfg_wdata[SLOTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (bytes_r == '0) begin
      eff_bytes = BYTES_W'(1);
    end else if (bytes_r > BYTES_MAX) begin
      eff_bytes = BYTES_MAX;
    end else begin
      eff_bytes = bytes_r;
    end
    if (bps_r == '0) begin
      per_eff = PER_W'(1);
    end else if (bps_r > PER_MAX) begin
      per_eff = PER_MAX;
    end else begin
      per_eff = bps_r;
    end
    sir_eff = (sir_r == '0) ? SLOTS_W'(1) : sir_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
  end

  // Buffers of slot s start at s*per; a slot cut short by the pool end
  // keeps only the buffers that exist.
  always_comb begin
    int room;
    slot_ok  = (SLOTS_W'(req_r.slot) < sir_eff) && (int'(req_r.slot) < MAX_SLOTS);
    base_dec = BASE_W'(req_r.slot) * BASE_W'(per_eff);
    room     = POOL_SIZE - int'(base_dec);
    if (!slot_ok || int'(base_dec) >= POOL_SIZE) begin
      n_dec = '0;
    end else if (room < int'(per_eff)) begin
      n_dec = PER_W'(room);
    end else begin
      n_dec = per_eff;
    end
    idx_ext     = BASE_W'(req_r.buffer_index);
    in_slot_dec = (n_dec != '0) && (idx_ext >= base_dec) &&
                  ((idx_ext - base_dec) < BASE_W'(n_dec));
    ptr_cur     = slot_ok ? ptr_r[SPW'(req_r.slot)] : '0;
    pos0        = (PER_W'(ptr_cur) >= n_dec) ? '0 : ptr_cur;
    prod        = MUL_W'(req_r.buffer_index) * MUL_W'(eff_bytes);
  end

  assign issue_ok = (iss_cnt_r < n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else if (cmd.decode) begin
      chk_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      chk_vld_r <= issue_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      base_r    <= base_dec;
      n_r       <= n_dec;
      iss_pos_r <= pos0;
      iss_cnt_r <= '0;
      offset_r  <= prod[OFFS_W-1:0];
    end else if (cmd.scan && issue_ok) begin
      iss_pos_r <= next_pos(iss_pos_r, n_r);
      iss_cnt_r <= iss_cnt_r + PER_W'(1);
      chk_pos_r <= iss_pos_r;
    end
  end

  // Clearing pass sweeps one entry per cycle.
  assign clr_last = (clr_addr_r == PW'(POOL_SIZE - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_restart) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_write) begin
      clr_addr_r <= clr_last ? '0 : clr_addr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_restart) begin
      ptr_r <= '{default: '0};
    end else if (cmd.capture && req_r.action == ACT_FIND && cmd.status == ST_OK) begin
      ptr_r[SPW'(req_r.slot)] <= next_pos(chk_pos_r, n_r);
    end
  end

  assign rd_addr  = cmd.scan ? PW'(base_r + BASE_W'(iss_pos_r)) : PW'(req_r.buffer_index);
  assign acc_addr = PW'(req_r.buffer_index);

  always_comb begin
    cnt_new = rd_cnt_r;
    if (req_r.action == ACT_ACQUIRE) begin
      if (rd_cnt_r != {COUNT_WIDTH{1'b1}}) begin
        cnt_new = rd_cnt_r + COUNT_WIDTH'(1);
      end
    end else if (rd_cnt_r != '0) begin
      cnt_new = rd_cnt_r - COUNT_WIDTH'(1);
    end
    len_clamped = (req_r.length > eff_bytes) ? eff_bytes : req_r.length;
  end

  always_ff @(posedge clk) begin
    rd_cnt_r <= use_mem[rd_addr];
    rd_len_r <= len_mem[rd_addr];
    if (cmd.clr_write) begin
      use_mem[clr_addr_r] <= '0;
      len_mem[clr_addr_r] <= eff_bytes;
    end else if (cmd.access) begin
      if (req_r.action == ACT_WRITE) begin
        len_mem[acc_addr] <= len_clamped;
      end else begin
        use_mem[acc_addr] <= cnt_new;
      end
    end
  end

  always_comb begin
    stat           = '0;
    stat.is_find   = (req_r.action == ACT_FIND);
    stat.n_zero    = (n_dec == '0);
    stat.bad_len   = (req_r.action == ACT_WRITE) && (req_r.length == '0);
    stat.in_slot   = in_slot_dec;
    stat.scan_hit  = chk_vld_r && (rd_cnt_r == '0);
    stat.scan_full = !chk_vld_r && !issue_ok;
    stat.clr_last  = clr_last;
  end

  always_comb begin
    res_nxt             = '0;
    res_nxt.status      = cmd.status;
    res_nxt.found_index = req_r.buffer_index;
    if (req_r.action == ACT_FIND) begin
      res_nxt.found_index = (cmd.status == ST_OK) ?
                            IDX_W'(base_r + BASE_W'(chk_pos_r)) : '0;
    end else if (cmd.status == ST_OK) begin
      unique case (req_r.action)
        ACT_ACQUIRE: begin
          res_nxt.byte_offset   = offset_r;
          res_nxt.stored_length = rd_len_r;
        end
        ACT_WRITE: begin
          res_nxt.stored_length = len_clamped;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_r <= res_nxt;
    end
  end

  assign out_item = res_r;

endmodule

[verif/slot_buffer_pool_manager_top_tb.sv]
// Self-checking testbench for slot_buffer_pool_manager_top: a queued request driver,
// a result monitor and a cycle-free predictor of the pool bookkeeping.
// Depends on sbpm_pkg and the slot_buffer_pool_manager_top RTL.
module slot_buffer_pool_manager_top_tb import sbpm_pkg::*; ();

  localparam int POOL_SIZE = POOL_SIZE_DEF;
  localparam int MAX_SLOTS = MAX_SLOTS_DEF;
  localparam int COUNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;

  // The configuration port decodes two index bits; index 3 names no register.
  localparam logic [CFG_IDX_W-1:0] REG_UNLISTED = 2'd3;

  // Generous run limit, in clock periods of 10 time units.
  localparam int LIMIT_CYCLES = 2000000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  slot_buffer_pool_manager_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Requests waiting to be sent, and the results predicted for the requests that the
  // block has already taken, oldest first.
  in_item_t  pending_requests[$];
  out_item_t predicted_results[$];

  int mismatches = 0;
  int gap_left   = 0;
  int calm_left  = 0;

  // Appends a request at the back of the waiting list.
  function automatic void queue_request(in_item_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor state: the raw register values as written, and the pool bookkeeping.
  // ---------------------------------------------------------------------------
  logic [BYTES_W-1:0]         reg_bytes;
  logic [PER_W-1:0]           reg_per;
  logic [SLOTS_W-1:0]         reg_slots;
  logic [COUNT_WIDTH_DEF-1:0] use_cnt    [POOL_SIZE];
  logic [BYTES_W-1:0]         rec_len    [POOL_SIZE];
  logic [POS_W-1:0]           search_ptr [MAX_SLOTS];

  // Registers keep what was written; the bookkeeping uses values clamped into range.
  function automatic int eff_bytes();
    if (reg_bytes < 1) return 1;
    if (reg_bytes > BYTES_MAX) return int'(BYTES_MAX);
    return int'(reg_bytes);
  endfunction

  function automatic int eff_per_slot();
    if (reg_per < 1) return 1;
    if (reg_per > PER_MAX) return int'(PER_MAX);
    return int'(reg_per);
  endfunction

  function automatic int eff_slots();
    if (reg_slots < 1) return 1;
    if (reg_slots > MAX_SLOTS) return MAX_SLOTS;
    return int'(reg_slots);
  endfunction

  // Number of buffers that really exist in slot s. Slots past slots_in_use are
  // empty, and a slot that runs past the end of the pool is cut short.
  function automatic int slot_extent(int s, output int base);
    int per;
    per  = eff_per_slot();
    base = s * per;
    if (s >= eff_slots() || s >= MAX_SLOTS) return 0;
    if (base >= POOL_SIZE) return 0;
    if (POOL_SIZE - base < per) return POOL_SIZE - base;
    return per;
  endfunction

  // Buffer creation: every write to a listed register and the reset rebuild the whole pool.
  function automatic void rebuild_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      use_cnt[i] = '0;
      rec_len[i] = BYTES_W'(eff_bytes());
    end
    for (int i = 0; i < MAX_SLOTS; i++) search_ptr[i] = '0;
  endfunction

  function automatic void mirror_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BUFFER_BYTES:     reg_bytes = data[BYTES_W-1:0];
      REG_BUFFERS_PER_SLOT: reg_per   = data[PER_W-1:0];
      REG_SLOTS_IN_USE:     reg_slots = data[SLOTS_W-1:0];
      default:              return;
    endcase
    rebuild_pool();
  endfunction

  // Works out the single result of one request and updates the bookkeeping.
  function automatic out_item_t predict_pool(in_item_t req);
    out_item_t rsp;
    int        base, n, pos, idx, bytes, len;
    bit        hit;
    idx   = int'(req.buffer_index);
    bytes = eff_bytes();
    rsp.status        = ST_OK;
    rsp.found_index   = req.buffer_index;
    rsp.byte_offset   = '0;
    rsp.stored_length = '0;
    if (req.action == ACT_FIND) begin
      // Round-robin scan from the slot's pointer; a failed scan reports index zero
      // and leaves the pointer where it was.
      n = slot_extent(int'(req.slot), base);
      rsp.found_index = '0;
      if (n == 0) begin
        rsp.status = ST_NOT_FOUND;
      end else begin
        pos = int'(search_ptr[req.slot]);
        if (pos >= n) pos = 0;
        rsp.status = ST_FULL;
        hit = 1'b0;
        for (int k = 0; k < n; k++) begin
          if (!hit && use_cnt[base + pos] == 0) begin
            hit = 1'b1;
            rsp.status      = ST_OK;
            rsp.found_index = IDX_W'(base + pos);
            search_ptr[req.slot] = POS_W'((pos + 1 < n) ? pos + 1 : 0);
          end
          if (!hit) pos = (pos + 1 < n) ? pos + 1 : 0;
        end
      end
    end else if (req.action == ACT_WRITE && req.length == '0) begin
      // A zero length is refused before the index is even looked at.
      rsp.status = ST_BAD_LEN;
    end else begin
      n = slot_extent(int'(req.slot), base);
      if (n == 0 || idx < base || idx - base >= n) begin
        rsp.status = ST_NOT_FOUND;
      end else if (req.action == ACT_ACQUIRE) begin
        if (use_cnt[idx] < COUNT_MAX) use_cnt[idx] = use_cnt[idx] + 1'b1;
        rsp.byte_offset   = OFFS_W'(longint'(idx) * longint'(bytes));
        rsp.stored_length = rec_len[idx];
      end else if (req.action == ACT_RELEASE) begin
        if (use_cnt[idx] > 0) use_cnt[idx] = use_cnt[idx] - 1'b1;
      end else begin
        len = int'(req.length);
        rec_len[idx] = BYTES_W'((len > bytes) ? bytes : len);
        rsp.stored_length = rec_len[idx];
      end
    end
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk(action_t a, int s, int idx, int len);
    in_item_t r;
    r.action       = a;
    r.slot         = SLOT_W'(s);
    r.buffer_index = IDX_W'(idx);
    r.length       = BYTES_W'(len);
    return r;
  endfunction

  // Fully random request; also what sits on in_item while start is low.
  function automatic in_item_t noise_item();
    return mk(action_t'($urandom_range(3, 0)), $urandom_range(7, 0), $urandom_range(63, 0),
              $urandom_range(33554431, 0));
  endfunction

  // Lengths cluster around the buffer size, with zero and oversize values mixed in.
  function automatic int pick_length();
    int bytes;
    bytes = eff_bytes();
    case ($urandom_range(9, 0))
      0:       return 0;
      1:       return bytes;
      2:       return int'($urandom_range(33554431, bytes));
      3:       return int'($urandom_range(33554431, 0));
      4:       return int'(BYTES_MAX);
      default: return int'($urandom_range(bytes, 1));
    endcase
  endfunction

  // Mostly requests aimed at buffers that exist in a live slot, so that slots fill up
  // and drain; about one in ten is pure noise. acq_w tilts the balance toward acquire.
  function automatic void fill_random(int count, int acq_w);
    int r, s, n, base, idx, a;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99, 0);
      s = $urandom_range(eff_slots() - 1, 0);
      n = slot_extent(s, base);
      if (r < 10 || n == 0) begin
        queue_request(noise_item());
      end else begin
        idx = base + $urandom_range(n - 1, 0);
        // Now and then aim just outside the slot on either side.
        if ($urandom_range(19, 0) == 0) idx = ($urandom_range(1, 0) != 0) ? base + n : base - 1;
        a = $urandom_range(99, 0);
        if (a < 30)
          queue_request(mk(ACT_FIND, s, idx, $urandom_range(33554431, 0)));
        else if (a < 30 + acq_w)
          queue_request(mk(ACT_ACQUIRE, s, idx, $urandom_range(33554431, 0)));
        else if (a < 85)
          queue_request(mk(ACT_RELEASE, s, idx, $urandom_range(33554431, 0)));
        else
          queue_request(mk(ACT_WRITE, s, idx, pick_length()));
      end
    end
  endfunction

  // Idle time before the next request: mostly none or short, a few long ones, and
  // now and then a run of back-to-back requests.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(49, 0) == 0) begin
      calm_left = 30;
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(4, 1);
    if (r < 96) return $urandom_range(20, 5);
    return $urandom_range(120, 30);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, predicted 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. A request is taken at an edge where start is high and busy is
  // low; at that edge its result is predicted and queued. start stays high across
  // busy cycles until the request is taken, and then the next one follows after a
  // random gap. start and in_item each get exactly one assignment per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    logic     raise;
    in_item_t next_req;
    in_item_t taken;
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else begin
      raise = start;
      if (start && !busy) begin
        taken = pending_requests[0];
        pending_requests.delete(0);
        predicted_results.insert(predicted_results.size(), predict_pool(taken));
        raise    = 1'b0;
        gap_left = pick_gap();
      end
      if (!raise) begin
        if (gap_left > 0) gap_left--;
        else if (pending_requests.size() != 0) raise = 1'b1;
      end
      next_req = raise ? pending_requests[0] : noise_item();
      start   <= raise;
      in_item <= next_req;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. The block shows each result for one cycle only, so every cycle
  // with out_valid set is taken and checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result with no request outstanding", out_item, '0);
      end else begin
        want = predicted_results[0];
        predicted_results.delete(0);
        if (out_item.status !== want.status)
          report_mismatch("status", out_item.status, want.status);
        if (out_item.found_index !== want.found_index)
          report_mismatch("found_index", out_item.found_index, want.found_index);
        if (out_item.byte_offset !== want.byte_offset)
          report_mismatch("byte_offset", out_item.byte_offset, want.byte_offset);
        if (out_item.stored_length !== want.stored_length)
          report_mismatch("stored_length", out_item.stored_length, want.stored_length);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and phase control. Registers are only written with no request
  // in flight. Each listed write starts a clearing pass with busy high, and the
  // next write or request waits until that pass is over.
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= CFG_DATA_W'($urandom);
    mirror_config(idx, data);
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_all(logic [CFG_DATA_W-1:0] bytes, logic [CFG_DATA_W-1:0] per,
                         logic [CFG_DATA_W-1:0] slots);
    write_reg(REG_BUFFER_BYTES, bytes);
    write_reg(REG_BUFFERS_PER_SLOT, per);
    write_reg(REG_SLOTS_IN_USE, slots);
  endtask

  // Waits until every queued request was taken and every result has come back.
  task automatic drain();
    while (pending_requests.size() != 0 || predicted_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random settings: mostly a few buffers per slot so slots run full, sometimes wide or
  // out-of-range values, with junk above the used bits of the narrow registers.
  task automatic set_random();
    logic [CFG_DATA_W-1:0] bytes, per, slots;
    case ($urandom_range(9, 0))
      0, 1, 2:    bytes = CFG_DATA_W'($urandom);
      3, 4:       bytes = CFG_DATA_W'($urandom_range(16777216, 16000000));
      default:    bytes = CFG_DATA_W'($urandom_range(1000, 1));
    endcase
    per   = CFG_DATA_W'(($urandom_range(9, 0) < 7) ? $urandom_range(8, 1) : $urandom_range(127, 0));
    slots = CFG_DATA_W'($urandom_range(15, 0));
    if ($urandom_range(1, 0) != 0) begin
      per[CFG_DATA_W-1:PER_W]     = (CFG_DATA_W - PER_W)'($urandom);
      slots[CFG_DATA_W-1:SLOTS_W] = (CFG_DATA_W - SLOTS_W)'($urandom);
    end
    set_all(bytes, per, slots);
  endtask

  initial begin : phase_control
    // Registers come out of reset at one buffer of one byte in one slot.
    reg_bytes = BYTES_W'(1);
    reg_per   = PER_W'(1);
    reg_slots = SLOTS_W'(1);
    rebuild_pool();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: slot 0 holds only buffer 0, every other slot is empty.
    @(negedge clk);
    queue_request(mk(ACT_FIND, 0, 0, 0));
    queue_request(mk(ACT_ACQUIRE, 0, 0, 0));
    queue_request(mk(ACT_FIND, 0, 0, 0));          // slot full
    queue_request(mk(ACT_FIND, 1, 0, 0));          // unused slot
    queue_request(mk(ACT_FIND, 7, 63, 0));
    queue_request(mk(ACT_ACQUIRE, 0, 1, 0));       // index outside slot
    queue_request(mk(ACT_ACQUIRE, 1, 0, 0));
    queue_request(mk(ACT_RELEASE, 0, 0, 0));
    queue_request(mk(ACT_RELEASE, 0, 0, 0));       // count stays at zero
    queue_request(mk(ACT_WRITE, 0, 0, 0));         // zero length
    queue_request(mk(ACT_WRITE, 7, 63, 0));        // zero length, bad index
    queue_request(mk(ACT_WRITE, 0, 0, 33554431));  // clamped to buffer size
    queue_request(mk(ACT_WRITE, 0, 5, 5));
    queue_request(mk(ACT_ACQUIRE, 0, 0, 0));
    fill_random(60, 35);
    drain();

    // Largest buffers over a full pool of eight slots of eight.
    set_all(25'd16777216, 25'd8, 25'd8);
    @(negedge clk);
    queue_request(mk(ACT_ACQUIRE, 7, 63, 0));      // largest byte offset
    queue_request(mk(ACT_WRITE, 7, 63, 16777216));
    queue_request(mk(ACT_WRITE, 7, 63, 33554431));
    queue_request(mk(ACT_WRITE, 7, 56, 1));
    queue_request(mk(ACT_ACQUIRE, 7, 56, 0));
    queue_request(mk(ACT_FIND, 7, 0, 0));          // skips the used buffer
    queue_request(mk(ACT_FIND, 7, 0, 0));
    queue_request(mk(ACT_RELEASE, 3, 30, 0));
    queue_request(mk(ACT_ACQUIRE, 2, 24, 0));      // belongs to slot 3
    queue_request(mk(ACT_FIND, 0, 0, 0));
    fill_random(150, 40);
    drain();

    // All registers zero, clamped up to one. Drive one use count into saturation and
    // step it back down from the top.
    set_all(25'd0, 25'd0, 25'd0);
    @(negedge clk);
    repeat (COUNT_MAX + 1) queue_request(mk(ACT_ACQUIRE, 0, 0, 0));
    queue_request(mk(ACT_FIND, 0, 0, 0));
    repeat (3) queue_request(mk(ACT_RELEASE, 0, 0, 0));
    queue_request(mk(ACT_FIND, 0, 0, 0));
    fill_random(30, 30);
    drain();

    // All registers at the top of their fields, clamped down: one slot of 64 buffers.
    set_all(25'h1FFFFFF, 25'd127, 25'd15);
    @(negedge clk);
    queue_request(mk(ACT_FIND, 1, 0, 0));          // slot starts past the pool
    queue_request(mk(ACT_ACQUIRE, 1, 0, 0));
    queue_request(mk(ACT_ACQUIRE, 0, 63, 0));
    queue_request(mk(ACT_WRITE, 0, 0, 16777215));
    queue_request(mk(ACT_ACQUIRE, 0, 0, 0));
    queue_request(mk(ACT_FIND, 0, 0, 0));
    fill_random(120, 45);
    drain();

    // A write to the unlisted index must leave settings and bookkeeping alone.
    write_reg(REG_UNLISTED, CFG_DATA_W'($urandom));
    @(negedge clk);
    fill_random(60, 30);
    drain();

    // Ten per slot: slot 6 is cut short to four buffers and slot 7 is empty.
    set_all(CFG_DATA_W'($urandom_range(4096, 1)), 25'd10, 25'd8);
    @(negedge clk);
    for (int i = 60; i < 64; i++) queue_request(mk(ACT_ACQUIRE, 6, i, 0));
    queue_request(mk(ACT_FIND, 6, 0, 0));          // every buffer in use
    queue_request(mk(ACT_FIND, 7, 0, 0));
    queue_request(mk(ACT_ACQUIRE, 6, 59, 0));
    queue_request(mk(ACT_RELEASE, 6, 63, 0));
    queue_request(mk(ACT_FIND, 6, 0, 0));          // finds the last one
    fill_random(150, 35);
    drain();

    repeat (3) begin
      set_random();
      @(negedge clk);
      fill_random(100, $urandom_range(50, 20));
      drain();
    end

    // Anything the block still emits after the last drain is caught here.
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : run_limit
    #(LIMIT_CYCLES * 10);
    $display("FAILURE");
    $finish;
  end

endmodule
